[hw/rtl/cstm_pkg.sv]
// ============================================================================
// cstm_pkg
// Types, codes and helpers shared by the shutter timer menu modules.
// ============================================================================
package cstm_pkg;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned SET_W   = 8;
    localparam int unsigned CNT_W   = 20;
    localparam int unsigned MENU_W  = 4;
    localparam int unsigned KIND_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SET_W-1:0] SET_MAX = 8'd254;
    localparam logic [SET_W-1:0] SET_MIN = 8'd1;

    localparam logic [SET_W-1:0] SELF_DELAY_RST = 8'd10;
    localparam logic [SET_W-1:0] LAPSE_RST      = 8'd10;
    localparam logic [SET_W-1:0] EXPOSURE_RST   = 8'd30;
    localparam logic [CFG_W-1:0] TPS_RST        = 13'd100;
    localparam logic [CFG_W-1:0] PULSE_RST      = 13'd1;

    // config register indexes
    localparam logic REG_TICKS_PER_SECOND = 1'b0;
    localparam logic REG_PULSE_TICKS      = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INC    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEC    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd5;

    // menu state numbers
    localparam logic [MENU_W-1:0] MS_INIT         = 4'd0;
    localparam logic [MENU_W-1:0] MS_SELF_BROWSE  = 4'd1;
    localparam logic [MENU_W-1:0] MS_SELF_SELECT  = 4'd2;
    localparam logic [MENU_W-1:0] MS_SELF_ACTIVE  = 4'd3;
    localparam logic [MENU_W-1:0] MS_LAPSE_BROWSE = 4'd4;
    localparam logic [MENU_W-1:0] MS_LAPSE_SELECT = 4'd5;
    localparam logic [MENU_W-1:0] MS_LAPSE_ACTIVE = 4'd6;
    localparam logic [MENU_W-1:0] MS_BULB_BROWSE  = 4'd7;
    localparam logic [MENU_W-1:0] MS_BULB_SELECT  = 4'd8;
    localparam logic [MENU_W-1:0] MS_BULB_ACTIVE  = 4'd9;
    localparam logic [MENU_W-1:0] MS_DBULB_BROWSE = 4'd10;
    localparam logic [MENU_W-1:0] MS_DBULB_SELECT = 4'd11;
    localparam logic [MENU_W-1:0] MS_DBULB_ACTIVE = 4'd12;
    localparam logic [MENU_W-1:0] MS_TBULB_BROWSE = 4'd13;
    localparam logic [MENU_W-1:0] MS_TBULB_SELECT = 4'd14;
    localparam logic [MENU_W-1:0] MS_TBULB_ACTIVE = 4'd15;

    typedef enum logic [15:0] {
        ST_INIT         = 16'h0001,
        ST_SELF_BROWSE  = 16'h0002,
        ST_SELF_SELECT  = 16'h0004,
        ST_SELF_ACTIVE  = 16'h0008,
        ST_LAPSE_BROWSE = 16'h0010,
        ST_LAPSE_SELECT = 16'h0020,
        ST_LAPSE_ACTIVE = 16'h0040,
        ST_BULB_BROWSE  = 16'h0080,
        ST_BULB_SELECT  = 16'h0100,
        ST_BULB_ACTIVE  = 16'h0200,
        ST_DBULB_BROWSE = 16'h0400,
        ST_DBULB_SELECT = 16'h0800,
        ST_DBULB_ACTIVE = 16'h1000,
        ST_TBULB_BROWSE = 16'h2000,
        ST_TBULB_SELECT = 16'h4000,
        ST_TBULB_ACTIVE = 16'h8000
    } menu_state_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_OPEN = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_BROWSE = 2'd0,
        ROLE_SELECT = 2'd1,
        ROLE_ACTIVE = 2'd2,
        ROLE_INIT   = 2'd3
    } role_t;

    typedef struct packed {
        logic [CFG_W-1:0] ticks_per_second;
        logic [CFG_W-1:0] pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic [MENU_W-1:0] menu_state;
        logic              shutter_held;
        logic [SET_W-1:0]  shown_value;
        logic [1:0]        blink_mode;
    } result_t;

    function automatic logic [MENU_W-1:0] menu_num(input menu_state_t st);
        logic [MENU_W-1:0] num;
        num = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (st[i])
            begin
                num = num | MENU_W'(i);
            end
        end
        return num;
    endfunction

    function automatic menu_state_t menu_onehot(input logic [MENU_W-1:0] num);
        return menu_state_t'(16'h0001 << num);
    endfunction

    function automatic role_t role_of(input logic [MENU_W-1:0] num);
        role_t r;
        unique case (num)
            MS_SELF_BROWSE, MS_LAPSE_BROWSE, MS_BULB_BROWSE,
            MS_DBULB_BROWSE, MS_TBULB_BROWSE: r = ROLE_BROWSE;
            MS_SELF_SELECT, MS_LAPSE_SELECT, MS_BULB_SELECT,
            MS_DBULB_SELECT, MS_TBULB_SELECT: r = ROLE_SELECT;
            MS_SELF_ACTIVE, MS_LAPSE_ACTIVE, MS_BULB_ACTIVE,
            MS_DBULB_ACTIVE, MS_TBULB_ACTIVE: r = ROLE_ACTIVE;
            default:                          r = ROLE_INIT;
        endcase
        return r;
    endfunction

    function automatic logic [SET_W-1:0] adjust(input logic [SET_W-1:0] v,
                                                input logic [KIND_W-1:0] kind);
        logic [SET_W-1:0] r;
        r = v;
        if (kind == KIND_INC && v < SET_MAX)
        begin
            r = v + 8'd1;
        end
        else if (kind == KIND_DEC && v > SET_MIN)
        begin
            r = v - 8'd1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/cstm_cfg.sv]
// ============================================================================
// cstm_cfg
// Configuration registers: ticks per second and shutter pulse length.
// ============================================================================
module cstm_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic                       wr_index,
    input  logic [cstm_pkg::CFG_W-1:0] wr_data,
    output cstm_pkg::cfg_t             cfg
);

    logic [cstm_pkg::CFG_W-1:0] tps_reg;
    logic [cstm_pkg::CFG_W-1:0] pulse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= cstm_pkg::TPS_RST;
            pulse_reg <= cstm_pkg::PULSE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cstm_pkg::REG_TICKS_PER_SECOND: tps_reg   <= wr_data;
                cstm_pkg::REG_PULSE_TICKS:      pulse_reg <= wr_data;
            endcase
        end
    end

    assign cfg.ticks_per_second = tps_reg;
    assign cfg.pulse_ticks      = pulse_reg;

endmodule

[hw/rtl/cstm_core.sv]
// ============================================================================
// cstm_core
// Menu state machine, settings and tick counter; one event per step.
// ============================================================================
module cstm_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [cstm_pkg::KIND_W-1:0] kind,
    input  logic                        pot_ready,
    input  cstm_pkg::cfg_t              cfg,
    output cstm_pkg::result_t           res
);

    cstm_pkg::menu_state_t      state_reg;
    cstm_pkg::menu_state_t      state_next;
    cstm_pkg::phase_t           phase_reg;
    cstm_pkg::phase_t           phase_next;
    logic [cstm_pkg::SET_W-1:0] self_delay_reg;
    logic [cstm_pkg::SET_W-1:0] self_delay_next;
    logic [cstm_pkg::SET_W-1:0] lapse_reg;
    logic [cstm_pkg::SET_W-1:0] lapse_next;
    logic [cstm_pkg::SET_W-1:0] exposure_reg;
    logic [cstm_pkg::SET_W-1:0] exposure_next;
    logic [cstm_pkg::CNT_W-1:0] tick_reg;
    logic [cstm_pkg::CNT_W-1:0] tick_next;
    logic                       shutter_reg;
    logic                       shutter_next;

    logic [cstm_pkg::MENU_W-1:0] cur;
    logic [cstm_pkg::MENU_W-1:0] num_next;
    cstm_pkg::role_t             role_cur;
    cstm_pkg::role_t             role_new;
    logic [cstm_pkg::SET_W-1:0]  secs_sel;
    logic [cstm_pkg::CNT_W:0]    prod;
    logic [cstm_pkg::CNT_W-1:0]  sat_ticks;
    logic [cstm_pkg::CNT_W-1:0]  cnt_inc;
    logic [cstm_pkg::CNT_W-1:0]  target;
    logic                        reached;
    logic                        is_repeat;

    assign cur      = cstm_pkg::menu_num(state_reg);
    assign role_cur = cstm_pkg::role_of(cur);

    always_comb
    begin
        unique case (cur)
            cstm_pkg::MS_SELF_ACTIVE:  secs_sel = self_delay_reg;
            cstm_pkg::MS_LAPSE_ACTIVE: secs_sel = lapse_reg;
            cstm_pkg::MS_DBULB_ACTIVE: secs_sel = 8'd1;
            default:                   secs_sel = exposure_reg;
        endcase
    end

    assign prod      = (cstm_pkg::CNT_W+1)'(secs_sel)
                     * (cstm_pkg::CNT_W+1)'(cfg.ticks_per_second);
    assign sat_ticks = prod[cstm_pkg::CNT_W] ? cstm_pkg::CNT_MAX : prod[cstm_pkg::CNT_W-1:0];
    assign cnt_inc   = (tick_reg == cstm_pkg::CNT_MAX) ? cstm_pkg::CNT_MAX
                                                       : tick_reg + 20'd1;
    assign is_repeat = (cur == cstm_pkg::MS_SELF_ACTIVE) || (cur == cstm_pkg::MS_LAPSE_ACTIVE);
    assign target    = (is_repeat && phase_reg == cstm_pkg::PH_OPEN)
                     ? cstm_pkg::CNT_W'(cfg.pulse_ticks) : sat_ticks;
    assign reached   = cnt_inc >= target;

    always_comb
    begin
        num_next        = cur;
        phase_next      = phase_reg;
        self_delay_next = self_delay_reg;
        lapse_next      = lapse_reg;
        exposure_next   = exposure_reg;
        tick_next       = tick_reg;
        shutter_next    = shutter_reg;

        unique case (role_cur)
            cstm_pkg::ROLE_INIT:
            begin
                if (pot_ready)
                begin
                    num_next = cstm_pkg::MS_SELF_BROWSE;
                end
            end
            cstm_pkg::ROLE_BROWSE:
            begin
                if (kind == cstm_pkg::KIND_OK)
                begin
                    num_next = cur + 4'd1;
                end
                else if (kind == cstm_pkg::KIND_INC)
                begin
                    num_next = (cur == cstm_pkg::MS_TBULB_BROWSE) ? cstm_pkg::MS_SELF_BROWSE
                                                                  : cur + 4'd3;
                end
                else if (kind == cstm_pkg::KIND_DEC)
                begin
                    num_next = (cur == cstm_pkg::MS_SELF_BROWSE) ? cstm_pkg::MS_TBULB_BROWSE
                                                                 : cur - 4'd3;
                end
            end
            cstm_pkg::ROLE_SELECT:
            begin
                if (kind == cstm_pkg::KIND_OK)
                begin
                    num_next     = cur + 4'd1;
                    tick_next    = '0;
                    phase_next   = cstm_pkg::PH_WAIT;
                    shutter_next = (cur == cstm_pkg::MS_BULB_SELECT)
                                || (cur == cstm_pkg::MS_TBULB_SELECT);
                end
                else if (kind == cstm_pkg::KIND_CANCEL)
                begin
                    num_next = cur - 4'd1;
                end
                else if (cur == cstm_pkg::MS_SELF_SELECT)
                begin
                    self_delay_next = cstm_pkg::adjust(self_delay_reg, kind);
                end
                else if (cur == cstm_pkg::MS_LAPSE_SELECT)
                begin
                    lapse_next = cstm_pkg::adjust(lapse_reg, kind);
                end
                else if (cur == cstm_pkg::MS_TBULB_SELECT)
                begin
                    exposure_next = cstm_pkg::adjust(exposure_reg, kind);
                end
            end
            cstm_pkg::ROLE_ACTIVE:
            begin
                if (kind == cstm_pkg::KIND_CANCEL)
                begin
                    shutter_next = 1'b0;
                    phase_next   = cstm_pkg::PH_WAIT;
                    tick_next    = '0;
                    num_next     = cur - 4'd1;
                end
                else if (kind == cstm_pkg::KIND_TICK)
                begin
                    if (is_repeat)
                    begin
                        if (phase_reg == cstm_pkg::PH_WAIT)
                        begin
                            tick_next = cnt_inc;
                            if (reached)
                            begin
                                shutter_next = 1'b1;
                                tick_next    = '0;
                                phase_next   = cstm_pkg::PH_OPEN;
                            end
                        end
                        else if (phase_reg == cstm_pkg::PH_OPEN)
                        begin
                            tick_next = cnt_inc;
                            if (reached)
                            begin
                                shutter_next = 1'b0;
                                tick_next    = '0;
                                phase_next   = (cur == cstm_pkg::MS_SELF_ACTIVE)
                                             ? cstm_pkg::PH_DONE : cstm_pkg::PH_WAIT;
                            end
                        end
                    end
                    else if (cur == cstm_pkg::MS_DBULB_ACTIVE)
                    begin
                        if (phase_reg == cstm_pkg::PH_WAIT)
                        begin
                            tick_next = cnt_inc;
                            if (reached)
                            begin
                                shutter_next = 1'b1;
                                phase_next   = cstm_pkg::PH_OPEN;
                            end
                        end
                    end
                    else if (cur == cstm_pkg::MS_TBULB_ACTIVE)
                    begin
                        tick_next = cnt_inc;
                        if (reached)
                        begin
                            shutter_next = 1'b0;
                            tick_next    = '0;
                            phase_next   = cstm_pkg::PH_WAIT;
                            num_next     = cstm_pkg::MS_TBULB_SELECT;
                        end
                    end
                end
            end
        endcase
    end

    assign state_next = cstm_pkg::menu_onehot(num_next);
    assign role_new   = cstm_pkg::role_of(num_next);

    always_comb
    begin
        res.menu_state   = num_next;
        res.shutter_held = shutter_next;
        res.blink_mode   = (role_new == cstm_pkg::ROLE_INIT) ? 2'd0 : 2'(role_new);
        res.shown_value  = '0;
        if (role_new == cstm_pkg::ROLE_SELECT || role_new == cstm_pkg::ROLE_ACTIVE)
        begin
            if (num_next <= cstm_pkg::MS_SELF_ACTIVE)
            begin
                res.shown_value = self_delay_next;
            end
            else if (num_next <= cstm_pkg::MS_LAPSE_ACTIVE)
            begin
                res.shown_value = lapse_next;
            end
            else if (num_next >= cstm_pkg::MS_TBULB_BROWSE)
            begin
                res.shown_value = exposure_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cstm_pkg::ST_INIT;
            phase_reg      <= cstm_pkg::PH_WAIT;
            self_delay_reg <= cstm_pkg::SELF_DELAY_RST;
            lapse_reg      <= cstm_pkg::LAPSE_RST;
            exposure_reg   <= cstm_pkg::EXPOSURE_RST;
            tick_reg       <= '0;
            shutter_reg    <= 1'b0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            self_delay_reg <= self_delay_next;
            lapse_reg      <= lapse_next;
            exposure_reg   <= exposure_next;
            tick_reg       <= tick_next;
            shutter_reg    <= shutter_next;
        end
    end

endmodule

[hw/rtl/camera_shutter_timer_menu.sv]
// ============================================================================
// camera_shutter_timer_menu
// Camera remote menu controller: self-timer, time-lapse, bulb, delayed bulb
// and timed bulb modes driven by button and timer tick events.
// ============================================================================
// Usage:
//   s_* stream carries one event per beat: tuser holds the event kind,
//   tdata[0] the front-end ready flag. m_* stream returns one beat per event
//   with the menu state, shutter level, shown setting and blink mode after
//   that event. cfg_* writes ticks_per_second (index 0) or pulse_ticks
//   (index 1); write only while no event is in flight.
// Path: an accepted event is held in the input register and processed by the
//   core logic; its result is registered into the output register, from which
//   m_* presents it until it is taken.
// Throughput: one event per cycle, back to back, while m_tready is high; the
//   whole menu update is one pass of logic between input and result registers.
// Reset: menu in init, settings 10/10/30 seconds, shutter closed, config
//   registers 100 ticks per second and 1 tick pulse, both streams empty.
// Stall: a result waits in the output register while m_tready is low; one
//   more event is held in the input register, then s_tready drops.
// ============================================================================
module camera_shutter_timer_menu
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] pot_ready, [7:1] zero
    input  logic [cstm_pkg::KIND_W-1:0] s_tuser,   // [2:0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [3:0] menu_state, [4] shutter_held,
                                                   // [12:5] shown_value, [14:13] blink_mode,
                                                   // [15] zero
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [cstm_pkg::CFG_W-1:0]  cfg_data
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [cstm_pkg::KIND_W-1:0] kind_reg;
    logic                        pot_ready_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    cstm_pkg::result_t           out_reg;
    cstm_pkg::result_t           res;
    cstm_pkg::cfg_t              cfg;
    logic                        advance;
    logic                        in_take;

    assign cfg_ready = 1'b1;

    cstm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cstm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .kind      (kind_reg),
        .pot_ready (pot_ready_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign advance        = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready       = ~in_valid_reg | advance;
    assign in_take        = s_tvalid & s_tready;
    assign in_valid_next  = in_take | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg      <= s_tuser;
            pot_ready_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.blink_mode, out_reg.shown_value,
                       out_reg.shutter_held, out_reg.menu_state};

endmodule
